### rtl/jve_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint velocity estimator package
// Shared constants and register indexes for the velocity estimator.
// ----------------------------------------------------------------------------
package jve_pkg;
   localparam int JOINTS_DEFAULT = 6;
   localparam int DT_MAX_US = 100000;

   typedef enum logic [1:0] {
      CSR_USE_FILTER  = 2'd0,
      CSR_ALPHA_GAIN  = 2'd1,
      CSR_BETA_GAIN   = 2'd2,
      CSR_FALLBACK_DT = 2'd3
   } csr_index_type;

   localparam logic [15:0] ALPHA_RESET = 16'd32768;
   localparam logic [15:0] BETA_RESET = 16'd983;
   localparam logic [16:0] FALLBACK_RESET = 17'd10000;
endpackage

### rtl/joint_velocity_estimator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint velocity estimator
// Per-joint alpha-beta tracker or finite difference over a shared multiplier
// and a shared bit-serial divider.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake
//  req_     | in        | req_valid / req_stall
//  rsp_     | out       | rsp_valid / rsp_stall
//  csr_     | in        | csr_write, no wait
// Filter mode runs a reciprocal prediction step and one division per joint;
// raw mode runs one division per joint, or none when the step is invalid.
// Restart or the first request gives a response the cycle after acceptance.
// Reset is synchronous; it restores default settings and clears control and joint state.
// req_stall stays high from acceptance until the response is taken.
module joint_velocity_estimator_unit #(
   parameter int JOINTS = jve_pkg::JOINTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_0,
   input  logic signed [31:0] req_pos_1,
   input  logic signed [31:0] req_pos_2,
   input  logic signed [31:0] req_pos_3,
   input  logic signed [31:0] req_pos_4,
   input  logic signed [31:0] req_pos_5,
   input  logic        [31:0] req_time_us,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_vel_0,
   output logic signed [31:0] rsp_vel_1,
   output logic signed [31:0] rsp_vel_2,
   output logic signed [31:0] rsp_vel_3,
   output logic signed [31:0] rsp_vel_4,
   output logic signed [31:0] rsp_vel_5,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_data
);
   import jve_pkg::*;

   localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   // floor(2^52 / 10^6), the reciprocal used for the prediction step.
   localparam logic signed [33:0] RECIP_1E6 = 34'sd4503599627;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PRED_MUL, ST_PRED_EST, ST_PRED_REM, ST_PRED_FIX, ST_RESID,
      ST_ALPHA, ST_BETA_DIV, ST_RAW_DIV, ST_NEXT, ST_OUT
   } state_type;

   state_type state_ff;
   logic        use_filter_ff;
   logic [15:0] alpha_ff, beta_ff;
   logic [16:0] fallback_ff;
   logic signed [31:0] pos_ff [JOINTS];
   logic signed [31:0] vel_ff [JOINTS];
   logic signed [31:0] meas_ff [JOINTS];
   logic [31:0] last_time_ff;
   logic        primed_ff;
   logic [JW-1:0] jidx_ff;
   logic [31:0] dt_ff;
   logic        valid_dt_ff;
   logic signed [79:0] pred_ff, resid_ff, work_ff;
   logic        pneg_ff;
   logic [47:0] pmag_ff;
   logic [28:0] pq_ff;
   logic [21:0] prem_ff;
   logic signed [79:0] pq_signed;
   logic        div_start_ff;
   logic signed [79:0] div_num_ff;
   logic [39:0] div_den_ff;
   logic        div_done;
   logic signed [79:0] div_quo;
   logic signed [31:0] pos_in [JOINTS];

   assign pos_in[0] = req_pos_0;
   if (JOINTS > 1) begin : g1 assign pos_in[1] = req_pos_1; end
   if (JOINTS > 2) begin : g2 assign pos_in[2] = req_pos_2; end
   if (JOINTS > 3) begin : g3 assign pos_in[3] = req_pos_3; end
   if (JOINTS > 4) begin : g4 assign pos_in[4] = req_pos_4; end
   if (JOINTS > 5) begin : g5 assign pos_in[5] = req_pos_5; end

   jve_divider u_div (
      .clock(clock), .reset(reset), .start(div_start_ff), .num(div_num_ff),
      .den(div_den_ff), .done(div_done), .quo(div_quo)
   );

   function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
      if (x > 80'sd2147483647) return 32'sh7fffffff;
      if (x < -80'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   logic [31:0] d_comb;
   logic        d_valid;
   assign d_comb = req_time_us - last_time_ff;
   assign d_valid = (d_comb != 32'd0) && (d_comb <= 32'(DT_MAX_US));

   assign pq_signed = pneg_ff ? -$signed(80'(pq_ff)) : $signed(80'(pq_ff));

   // Single shared multiplier: 34 by 34 bits, results are registered.
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;
   always_comb begin
      mul_a = 34'(vel_ff[jidx_ff]);
      mul_b = 34'($signed({1'b0, dt_ff}));
      unique case (state_ff)
         ST_PRED_EST: begin
            mul_a = $signed({6'd0, pmag_ff[47:20]});
            mul_b = RECIP_1E6;
         end
         ST_ALPHA: begin
            mul_a = resid_ff[33:0];
            mul_b = 34'($signed({1'b0, alpha_ff}));
         end
         ST_RESID: begin
            mul_a = resid_ff[33:0];
            mul_b = 34'($signed({1'b0, beta_ff}));
         end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      div_start_ff <= 1'b0;
      if (reset) begin
         state_ff <= ST_IDLE;
         use_filter_ff <= 1'b1;
         alpha_ff <= ALPHA_RESET;
         beta_ff <= BETA_RESET;
         fallback_ff <= FALLBACK_RESET;
         last_time_ff <= '0;
         primed_ff <= 1'b0;
         jidx_ff <= '0;
         rsp_valid <= 1'b0;
         for (int j = 0; j < JOINTS; j++) begin
            pos_ff[j] <= '0;
            vel_ff[j] <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_USE_FILTER:  use_filter_ff <= csr_data[0];
               CSR_ALPHA_GAIN:  alpha_ff <= csr_data[15:0];
               CSR_BETA_GAIN:   beta_ff <= csr_data[15:0];
               CSR_FALLBACK_DT: fallback_ff <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  for (int j = 0; j < JOINTS; j++) meas_ff[j] <= pos_in[j];
                  last_time_ff <= req_time_us;
                  jidx_ff <= '0;
                  valid_dt_ff <= d_valid;
                  if (d_valid) dt_ff <= d_comb;
                  else if (fallback_ff == 17'd0) dt_ff <= 32'd1;
                  else dt_ff <= 32'(fallback_ff);
                  if (!primed_ff || req_restart) begin
                     primed_ff <= 1'b1;
                     for (int j = 0; j < JOINTS; j++) begin
                        pos_ff[j] <= pos_in[j];
                        vel_ff[j] <= '0;
                     end
                     state_ff <= ST_OUT;
                     rsp_valid <= 1'b1;
                  end else if (use_filter_ff) begin
                     state_ff <= ST_PRED_MUL;
                  end else begin
                     state_ff <= ST_RAW_DIV;
                     div_start_ff <= d_valid;
                     div_num_ff <= (80'(pos_in[0]) - 80'(pos_ff[0])) * 80'sd1000000;
                     div_den_ff <= 40'(d_comb);
                  end
               end
            end
            ST_PRED_MUL: begin
               // Magnitude of v * dt biased by half of one million for rounding.
               pneg_ff <= mul_p[67];
               pmag_ff <= (mul_p[67] ? 48'(-mul_p) : 48'(mul_p)) + 48'd500000;
               state_ff <= ST_PRED_EST;
            end
            ST_PRED_EST: begin
               // The estimate is low by at most two; the fix-up state adds the rest.
               pq_ff <= mul_p[60:32];
               state_ff <= ST_PRED_REM;
            end
            ST_PRED_REM: begin
               prem_ff <= 22'(50'(pmag_ff) - 50'(pq_ff) * 50'd1000000);
               state_ff <= ST_PRED_FIX;
            end
            ST_PRED_FIX: begin
               if (prem_ff >= 22'd1000000) begin
                  prem_ff <= prem_ff - 22'd1000000;
                  pq_ff <= pq_ff + 29'd1;
               end else begin
                  pred_ff <= 80'(pos_ff[jidx_ff]) + pq_signed;
                  resid_ff <= 80'(meas_ff[jidx_ff]) - (80'(pos_ff[jidx_ff]) + pq_signed);
                  state_ff <= ST_RESID;
               end
            end
            ST_RESID: begin
               // Residual fits 34 bits at most; beta product times 15625 next.
               work_ff <= 80'(mul_p);
               state_ff <= ST_ALPHA;
            end
            ST_ALPHA: begin
               begin
                  logic signed [79:0] ap, np;
                  ap = 80'(mul_p);
                  np = ap[79] ? -((-ap + 80'sd32768) >>> 16) : ((ap + 80'sd32768) >>> 16);
                  pos_ff[jidx_ff] <= sat32(pred_ff + np);
               end
               div_num_ff <= work_ff * 80'sd15625;
               div_den_ff <= 40'(dt_ff) * 40'd1024;
               div_start_ff <= 1'b1;
               state_ff <= ST_BETA_DIV;
            end
            ST_BETA_DIV: if (div_done) begin
               vel_ff[jidx_ff] <= sat32(80'(vel_ff[jidx_ff]) + div_quo);
               state_ff <= ST_NEXT;
            end
            ST_RAW_DIV: if (div_done || !valid_dt_ff) begin
               vel_ff[jidx_ff] <= valid_dt_ff ? sat32(div_quo) : 32'sd0;
               pos_ff[jidx_ff] <= meas_ff[jidx_ff];
               state_ff <= ST_NEXT;
            end
            ST_NEXT: begin
               if (32'(jidx_ff) == JOINTS - 1) begin
                  state_ff <= ST_OUT;
                  rsp_valid <= 1'b1;
               end else begin
                  jidx_ff <= jidx_ff + 1'b1;
                  if (use_filter_ff) state_ff <= ST_PRED_MUL;
                  else begin
                     state_ff <= ST_RAW_DIV;
                     div_start_ff <= valid_dt_ff;
                     div_num_ff <= (80'(meas_ff[jidx_ff + 1'b1]) -
                                    80'(pos_ff[jidx_ff + 1'b1])) * 80'sd1000000;
                     div_den_ff <= 40'(dt_ff);
                  end
               end
            end
            ST_OUT: if (!rsp_stall) begin
               rsp_valid <= 1'b0;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_vel_0 = vel_ff[0];
   assign rsp_vel_1 = (JOINTS > 1) ? vel_ff[JW'(1 % JOINTS)] : 32'sd0;
   assign rsp_vel_2 = (JOINTS > 2) ? vel_ff[JW'(2 % JOINTS)] : 32'sd0;
   assign rsp_vel_3 = (JOINTS > 3) ? vel_ff[JW'(3 % JOINTS)] : 32'sd0;
   assign rsp_vel_4 = (JOINTS > 4) ? vel_ff[JW'(4 % JOINTS)] : 32'sd0;
   assign rsp_vel_5 = (JOINTS > 5) ? vel_ff[JW'(5 % JOINTS)] : 32'sd0;

   a_rsp_only_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_OUT) else $error("response outside output state");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while response pending");
   a_primed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> primed_ff) else $error("response before first sample");
endmodule

### rtl/jve_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint velocity estimator divider
// Signed dividend over unsigned divisor, rounded to nearest with ties away
// from zero; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jve_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [79:0] num,
   input  logic        [39:0] den,
   output logic               done,
   output logic signed [79:0] quo
);
   logic [79:0] mag_ff, mag_in;
   logic [80:0] rem_ff, rem_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        busy_ff, busy_in;
   logic [39:0] den_ff, den_in;
   logic [80:0] trial;
   logic [79:0] mag_abs;
   logic        done_ff, done_in;

   always_comb begin
      mag_abs = num[79] ? 80'(-num) : 80'(num);
      mag_in = mag_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      den_in = den_ff;
      done_in = 1'b0;
      trial = {rem_ff[79:0], mag_ff[79]};
      if (start) begin
         // Bias by half the divisor so truncation gives a rounded quotient.
         mag_in = mag_abs + 80'(den >> 1);
         rem_in = '0;
         cnt_in = 7'd80;
         neg_in = num[79];
         busy_in = 1'b1;
         den_in = den;
      end else if (busy_ff) begin
         if (trial >= 81'(den_ff)) begin
            rem_in = trial - 81'(den_ff);
            mag_in = {mag_ff[78:0], 1'b1};
         end else begin
            rem_in = trial;
            mag_in = {mag_ff[78:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // The quotient register holds the final value while done is high.
   assign quo = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);
   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      den_ff <= den_in;
   end
endmodule

### tb/sv/joint_velocity_estimator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint velocity estimator testbench
// Drives position samples through the estimator, first from a directed table
// and then from random joint trajectories with random timing. A local
// alpha-beta and finite-difference tracker predicts every velocity response,
// and each response is checked joint by joint in order of arrival.
// ----------------------------------------------------------------------------
module joint_velocity_estimator_unit_tb;
   import jve_pkg::*;

   localparam logic [31:0] P_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] P_MIN = 32'h8000_0000;
   localparam int RANDOM_ITEMS = 1900;

   typedef logic [5:0][31:0] joint_vec_type;
   typedef enum {ROW_REQ, ROW_CSR} row_kind_type;
   typedef struct {
      row_kind_type  kind;
      csr_index_type idx;
      logic [16:0]   data;
      joint_vec_type pos;
      logic [31:0]   t;
      bit            rst;
      bit            zero;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   joint_vec_type req_pos = '0;
   logic [31:0] req_time_us = '0;
   logic        req_restart = 1'b0;
   logic        req_zero = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   joint_vec_type rsp_vel;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [16:0] csr_data = '0;

   int  tx_idle_pct = 23;
   int  rx_idle_pct = 82;
   bit  hold_flip = 1'b0;
   int  mismatch_count = 0;
   joint_vec_type vel_expected_q[$];

   // Tracker state and register copy.
   logic signed [31:0] trk_pos[6];
   logic signed [31:0] trk_vel[6];
   logic [31:0] trk_time = '0;
   bit          trk_primed = 1'b0;
   bit          cfg_filter = 1'b1;
   logic [15:0] cfg_alpha = ALPHA_RESET;
   logic [15:0] cfg_beta = BETA_RESET;
   logic [16:0] cfg_fallback = FALLBACK_RESET;

   joint_velocity_estimator_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pos_0(req_pos[0]), .req_pos_1(req_pos[1]), .req_pos_2(req_pos[2]),
      .req_pos_3(req_pos[3]), .req_pos_4(req_pos[4]), .req_pos_5(req_pos[5]),
      .req_time_us(req_time_us), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_vel_0(rsp_vel[0]), .rsp_vel_1(rsp_vel[1]), .rsp_vel_2(rsp_vel[2]),
      .rsp_vel_3(rsp_vel[3]), .rsp_vel_4(rsp_vel[4]), .rsp_vel_5(rsp_vel[5]),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #200ms;
      $display("joint_velocity_estimator_unit verification failed");
      $finish;
   end

   // Rounds to nearest with ties away from zero.
   function automatic longint div_round(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic logic signed [31:0] clamp32(longint x);
      if (x > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (x < -longint'(64'h8000_0000)) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   function automatic joint_vec_type predict_velocity(joint_vec_type meas_in,
                                                      logic [31:0] t, bit rst);
      logic [31:0]   d;
      bit            step_ok;
      longint        dt, v, meas, pred, r, np, nv, a, b;
      joint_vec_type vel;
      d = t - trk_time;
      step_ok = (d >= 1) && (d <= DT_MAX_US);
      a = cfg_alpha;
      b = cfg_beta;
      if (!trk_primed || rst) begin
         for (int j = 0; j < 6; j++) begin
            trk_pos[j] = meas_in[j];
            trk_vel[j] = '0;
         end
         trk_primed = 1'b1;
      end else if (cfg_filter) begin
         if (step_ok) dt = d;
         else dt = cfg_fallback;
         if (dt == 0) dt = 1;
         for (int j = 0; j < 6; j++) begin
            v = trk_vel[j];
            meas = $signed(meas_in[j]);
            pred = longint'(trk_pos[j]) + div_round(v * dt, 1000000);
            r = meas - pred;
            np = pred + div_round(a * r, 65536);
            nv = v + div_round(b * r * 15625, 1024 * dt);
            trk_pos[j] = clamp32(np);
            trk_vel[j] = clamp32(nv);
         end
      end else begin
         for (int j = 0; j < 6; j++) begin
            meas = $signed(meas_in[j]);
            trk_vel[j] = '0;
            if (step_ok)
               trk_vel[j] = clamp32(div_round((meas - longint'(trk_pos[j])) * 1000000,
                                              longint'(d)));
            trk_pos[j] = meas_in[j];
         end
      end
      trk_time = t;
      for (int j = 0; j < 6; j++) vel[j] = trk_vel[j];
      return vel;
   endfunction

   // Observes register writes, accepted requests and taken responses.
   always @(posedge clock) begin
      joint_vec_type exp_vel, got;
      if (!reset) begin
         if (csr_write) begin
            case (csr_index)
               CSR_USE_FILTER:  cfg_filter = csr_data[0];
               CSR_ALPHA_GAIN:  cfg_alpha = csr_data[15:0];
               CSR_BETA_GAIN:   cfg_beta = csr_data[15:0];
               CSR_FALLBACK_DT: cfg_fallback = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_vel;
            if (vel_expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected response %h", got);
            end else begin
               exp_vel = vel_expected_q.pop_front();
               for (int j = 0; j < 6; j++) begin
                  if (got[j] !== exp_vel[j]) begin
                     mismatch_count++;
                     if (mismatch_count <= 10)
                        $display("vel_%0d mismatch: expected %h actual %h",
                                 j, exp_vel[j], got[j]);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            exp_vel = predict_velocity(req_pos, req_time_us, req_restart);
            // Pinned rows must come out all zero by construction.
            if (req_zero && exp_vel != '0) exp_vel = '0;
            vel_expected_q.push_back(exp_vel);
         end
      end
   end

   // Response side stall, with an occasional long hold-off.
   always @(posedge clock) begin
      int  hold_left;
      bit  hold_seen;
      if (hold_flip != hold_seen) begin
         hold_seen = hold_flip;
         hold_left = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   task automatic send_req(joint_vec_type p, logic [31:0] t, bit r, bit z);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos <= p;
      req_time_us <= t;
      req_restart <= r;
      req_zero <= z;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      // One edge first, so the request accepted at this edge is queued.
      @(posedge clock);
      while (vel_expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [16:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      row_type       plan[$];
      int            track[6];
      joint_vec_type p;
      logic [31:0]   t;
      int            roll;

      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0,
                       {P_MAX, P_MIN, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0100_0000},
                       32'd1000, 1'b0, 1'b1});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0,
                       {P_MAX, P_MIN, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0100_0000},
                       32'd11000, 1'b0, 1'b0});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0,
                       {P_MIN, P_MAX, P_MAX, P_MIN, 32'd0, 32'h0200_0000},
                       32'd21000, 1'b0, 1'b0});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{32'h0100_0000}},
                       32'd21000, 1'b0, 1'b0});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{32'h0080_0000}},
                       32'd20000, 1'b0, 1'b0});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{32'hFF00_0000}},
                       32'd120000, 1'b0, 1'b0});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{32'h0000_1000}},
                       32'd220001, 1'b0, 1'b0});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{32'h1234_5678}},
                       32'hFFFF_FFF0, 1'b1, 1'b1});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{32'h1234_6678}},
                       32'h0000_0010, 1'b0, 1'b0});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{32'h1234_6679}},
                       32'h0000_0011, 1'b0, 1'b0});
      plan.push_back('{ROW_CSR, CSR_USE_FILTER, 17'd0, '0, 0, 0, 0});
      plan.push_back('{ROW_CSR, CSR_FALLBACK_DT, 17'd0, '0, 0, 0, 0});
      plan.push_back('{ROW_CSR, CSR_ALPHA_GAIN, 17'hFFFF, '0, 0, 0, 0});
      plan.push_back('{ROW_CSR, CSR_BETA_GAIN, 17'hFFFF, '0, 0, 0, 0});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{32'h1244_6679}},
                       32'h0000_0020, 1'b0, 1'b0});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{P_MAX}}, 32'h21, 1'b0, 1'b0});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{P_MIN}}, 32'h22, 1'b0, 1'b0});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{P_MAX}}, 32'h22, 1'b0, 1'b1});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{32'd5}}, 32'd200034, 1'b0, 1'b1});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{32'd9}}, 32'd100, 1'b0, 1'b1});
      plan.push_back('{ROW_CSR, CSR_USE_FILTER, 17'd1, '0, 0, 0, 0});
      // A zero fallback with a zero step falls back to one microsecond.
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{32'h0001_0000}}, 32'd100, 1'b0, 1'b0});
      plan.push_back('{ROW_CSR, CSR_ALPHA_GAIN, 17'd0, '0, 0, 0, 0});
      plan.push_back('{ROW_CSR, CSR_BETA_GAIN, 17'd0, '0, 0, 0, 0});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{32'h0002_0000}}, 32'd5100, 1'b0, 1'b0});
      plan.push_back('{ROW_CSR, CSR_FALLBACK_DT, 17'd100000, '0, 0, 0, 0});
      plan.push_back('{ROW_CSR, CSR_ALPHA_GAIN, 17'd32768, '0, 0, 0, 0});
      plan.push_back('{ROW_CSR, CSR_BETA_GAIN, 17'd983, '0, 0, 0, 0});
      plan.push_back('{ROW_REQ, CSR_USE_FILTER, 0, {6{32'h0003_0000}}, 32'd5100, 1'b0, 1'b0});

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            wait_drain();
            write_csr(plan[i].idx, plan[i].data);
         end else begin
            send_req(plan[i].pos, plan[i].t, plan[i].rst, plan[i].zero);
         end
      end

      for (int j = 0; j < 6; j++) track[j] = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      t = 32'd0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 630 || n == 1260) begin
            wait_drain();
            tx_idle_pct = (n == 630) ? 82 : 0;
            rx_idle_pct <= (n == 630) ? 23 : 0;
         end
         if (n % 90 == 0) begin
            wait_drain();
            roll = $urandom_range(3);
            write_csr(CSR_USE_FILTER, ($urandom_range(99) < 60) ? 17'd1 : 17'd0);
            write_csr(CSR_ALPHA_GAIN, roll == 0 ? 17'd0 : roll == 1 ? 17'hFFFF
                                      : 17'($urandom_range(16'hFFFF)));
            roll = $urandom_range(3);
            write_csr(CSR_BETA_GAIN, roll == 0 ? 17'd0 : roll == 1 ? 17'hFFFF
                                     : 17'($urandom_range(16'hFFFF)));
            roll = $urandom_range(5);
            write_csr(CSR_FALLBACK_DT, roll == 0 ? 17'd1 : roll == 1 ? 17'd100000
                                       : roll == 2 ? 17'h1FFFF : roll == 3 ? 17'd0
                                       : 17'($urandom_range(1, 100000)));
         end
         if (n == 300 || n == 1500) hold_flip <= ~hold_flip;
         for (int j = 0; j < 6; j++) begin
            roll = $urandom_range(99);
            if (roll < 8) track[j] = $urandom;
            else if (roll < 11) track[j] = $urandom_range(1) ? P_MAX : P_MIN;
            else track[j] = track[j] + int'($urandom_range(400000)) - 200000;
            p[j] = track[j];
         end
         roll = $urandom_range(99);
         if (roll < 60) t = t + $urandom_range(5000, 15000);
         else if (roll < 85) t = t + $urandom_range(1, 100000);
         else if (roll < 90) t = t;
         else if (roll < 94) t = t + $urandom_range(100001, 32'h7FFF_FFFF);
         else if (roll < 97) t = t - $urandom_range(1, 1000);
         else t = $urandom;
         send_req(p, t, $urandom_range(99) < 3, 1'b0);
      end

      wait_drain();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && vel_expected_q.size() == 0) begin
         $display("joint_velocity_estimator_unit verification clean");
      end else begin
         $display("joint_velocity_estimator_unit verification failed");
      end
      $finish;
   end
endmodule
